// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of the project.
// Needs no other file; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define QPC_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in quadrature position checker");

// Implication that also holds across reset (no disable clause).
`define QPC_ASSERT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed in quadrature position checker");

`endif

// ===== hw/rtl/qpc_pkg.sv =====
// Package of the quadrature position counter: item types, codes, widths and
// the phase step helpers. Depends on nothing.
`default_nettype none

package qpc_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int ACCUM_WIDTH_DEF    = 32;

  localparam int REG_W      = 32;
  localparam int COOLDOWN_W = 16;
  localparam int TICK_W     = 32;
  localparam int POS_OUT_W  = 32;
  localparam int CFG_IDX_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 2'd3;

  localparam logic [REG_W-1:0]      RANGE_RST    = 32'd1023;
  localparam logic [REG_W-1:0]      INITIAL_RST  = 32'd0;
  localparam logic                  WRAP_RST     = 1'b0;
  localparam logic [COOLDOWN_W-1:0] COOLDOWN_RST = 16'd10;

  // Opcodes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_EDGE_A  = 3'd1;
  localparam logic [2:0] OP_EDGE_B  = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  typedef struct packed {
    logic [2:0] opcode;
    logic       level_a;
    logic       level_b;
  } in_item_t;

  typedef struct packed {
    logic [POS_OUT_W-1:0] position_out;
    logic                 hit_cap;
  } out_item_t;

  // Pins (A,B): 00=0, 10=1, 11=2, 01=3
  function automatic logic [1:0] phase_from_pins(input logic a, input logic b);
    phase_from_pins = {b, a ^ b};
  endfunction

  // Edge on A: flip bit 0; count up when leaving an even phase
  function automatic logic [1:0] phase_after_a(input logic [1:0] ph);
    phase_after_a = ph ^ 2'b01;
  endfunction

  // Edge on B: mirror the phase; count up when leaving an odd phase
  function automatic logic [1:0] phase_after_b(input logic [1:0] ph);
    phase_after_b = ~ph;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/quadrature_position_counter.sv =====
// Quadrature position counter: top level with the command decode, the
// shared restoring-division datapath and the result register. Uses qpc_pkg.
//
// Usage
//   Input channel (in_valid / in_stall / in_item): one item is a tick, an
//   edge on A or B, a read or a restart. Ticks, edges and restarts finish at
//   the accepting edge, so they may follow each other every cycle.
//   A read runs a remainder of the pending change by the range, one bit per
//   cycle through a single subtract-and-compare unit, then folds the
//   remainder into the position and writes the result item; in_stall stays
//   high from acceptance until then, so no other item is taken meanwhile.
//   Result channel (out_valid / out_stall / out_item): only reads give an
//   item. The result register holds it while out_stall is high; the block
//   keeps taking further items meanwhile and waits at the fold step only if
//   a second read finishes before the first result has been taken.
//   Configuration (cfg_we / cfg_index / cfg_wdata): write only while idle.
//   Reset (rst_n low, synchronous): registers to their defaults, position,
//   phase, pending change and timestamps to zero, result channel empty.
`default_nettype none

module quadrature_position_counter #(
  parameter int POSITION_WIDTH = qpc_pkg::POSITION_WIDTH_DEF,
  parameter int ACCUM_WIDTH    = qpc_pkg::ACCUM_WIDTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  qpc_pkg::in_item_t         in_item,
  output logic                            out_valid,
  input  wire                             out_stall,
  output qpc_pkg::out_item_t              out_item,
  input  wire                             cfg_we,
  input  wire  [qpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [qpc_pkg::REG_W-1:0]       cfg_wdata
);

  localparam int PW    = POSITION_WIDTH;
  localparam int AW    = ACCUM_WIDTH;
  localparam int NPW   = PW + 2;
  localparam int CNT_W = $clog2(AW + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  localparam logic [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  // Configuration registers
  logic [qpc_pkg::REG_W-1:0]      range_r,    range_nxt;
  logic [qpc_pkg::REG_W-1:0]      initial_r,  initial_nxt;
  logic                           wrap_r,     wrap_nxt;
  logic [qpc_pkg::COOLDOWN_W-1:0] cooldown_r, cooldown_nxt;

  // Architectural state
  logic [PW-1:0]                  pos_r,     pos_nxt;
  logic [1:0]                     phase_r,   phase_nxt;
  logic [AW-1:0]                  pending_r, pending_nxt;
  logic [qpc_pkg::TICK_W-1:0]     now_r,     now_nxt;
  logic [qpc_pkg::TICK_W-1:0]     last_a_r,  last_a_nxt;
  logic [qpc_pkg::TICK_W-1:0]     last_b_r,  last_b_nxt;

  // Sequencer and division datapath
  logic [1:0]                     state_r,   state_nxt;
  logic [CNT_W-1:0]               cnt_r,     cnt_nxt;
  logic [AW-1:0]                  mag_r,     mag_nxt;
  logic [PW-1:0]                  rem_r,     rem_nxt;
  logic                           neg_r,     neg_nxt;
  logic                           la_r,      la_nxt;
  logic                           lb_r,      lb_nxt;

  // Result register
  logic                           out_valid_r, out_valid_nxt;
  qpc_pkg::out_item_t             out_item_r,  out_item_nxt;

  // Combinational helpers
  logic                           in_fire;
  logic [PW-1:0]                  range_now;
  logic [PW-1:0]                  init_now;
  logic [qpc_pkg::TICK_W-1:0]     elapsed_a, elapsed_b;
  logic                           edge_a_ok, edge_b_ok;
  logic                           step_up;
  logic                           step_en;
  logic [AW-1:0]                  pending_step;
  logic [PW:0]                    rem_sh;
  logic                           rem_ge;
  logic [NPW-1:0]                 chg;
  logic [NPW-1:0]                 np;
  logic                           np_neg, np_over;
  logic [PW-1:0]                  wrap_lo, wrap_hi;
  logic [PW-1:0]                  pos_fold;
  logic                           cap_fold;
  logic                           out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign range_now = range_r[PW-1:0];
  assign init_now  = initial_r[PW-1:0];

  // Cooldown: an edge counts once the channel's quiet time has run out
  assign elapsed_a = now_r - last_a_r;
  assign elapsed_b = now_r - last_b_r;
  assign edge_a_ok = elapsed_a >= qpc_pkg::TICK_W'(cooldown_r);
  assign edge_b_ok = elapsed_b >= qpc_pkg::TICK_W'(cooldown_r);

  // Saturating +/-1 on the pending change
  always_comb begin
    step_up = 1'b0;
    step_en = 1'b0;
    if (in_item.opcode == qpc_pkg::OP_EDGE_A) begin
      step_up = !phase_r[0];
      step_en = edge_a_ok;
    end else if (in_item.opcode == qpc_pkg::OP_EDGE_B) begin
      step_up = phase_r[0];
      step_en = edge_b_ok;
    end
    pending_step = pending_r;
    if (step_up && pending_r != ACC_MAX) begin
      pending_step = pending_r + AW'(1);
    end else if (!step_up && pending_r != ACC_MIN) begin
      pending_step = pending_r - AW'(1);
    end
  end

  // One restoring-division step: shift in the next dividend bit, subtract
  assign rem_sh = {rem_r, mag_r[AW-1]};
  assign rem_ge = rem_sh >= {1'b0, range_now};

  // Fold the signed remainder into the position, then wrap or clamp
  always_comb begin
    chg = {2'b00, rem_r};
    if (range_now == '0) begin
      chg = '0;
    end else if (neg_r) begin
      chg = ~{2'b00, rem_r} + NPW'(1);
    end
    np       = {2'b00, pos_r} + chg;
    np_neg   = np[NPW-1];
    np_over  = !np_neg && (np > {2'b00, range_now});
    wrap_lo  = PW'({2'b00, range_now} + np + NPW'(1));
    wrap_hi  = PW'(np - {2'b00, range_now} - NPW'(1));
    cap_fold = np_neg || np_over;
    if (np_neg) begin
      pos_fold = wrap_r ? wrap_lo : '0;
    end else if (np_over) begin
      pos_fold = wrap_r ? wrap_hi : range_now;
    end else begin
      pos_fold = np[PW-1:0];
    end
  end

  always_comb begin
    range_nxt     = range_r;
    initial_nxt   = initial_r;
    wrap_nxt      = wrap_r;
    cooldown_nxt  = cooldown_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    pending_nxt   = pending_r;
    now_nxt       = now_r;
    last_a_nxt    = last_a_r;
    last_b_nxt    = last_b_r;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    la_nxt        = la_r;
    lb_nxt        = lb_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    // Drop the result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        qpc_pkg::CFG_RANGE:    range_nxt    = cfg_wdata;
        qpc_pkg::CFG_INITIAL:  initial_nxt  = cfg_wdata;
        qpc_pkg::CFG_WRAP:     wrap_nxt     = cfg_wdata[0];
        qpc_pkg::CFG_COOLDOWN: cooldown_nxt = cfg_wdata[qpc_pkg::COOLDOWN_W-1:0];
        default:               range_nxt    = range_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_item.opcode)
            qpc_pkg::OP_TICK: begin
              now_nxt = now_r + qpc_pkg::TICK_W'(1);
            end
            qpc_pkg::OP_EDGE_A: begin
              if (step_en) begin
                pending_nxt = pending_step;
                phase_nxt   = qpc_pkg::phase_after_a(phase_r);
                last_a_nxt  = now_r;
              end
            end
            qpc_pkg::OP_EDGE_B: begin
              if (step_en) begin
                pending_nxt = pending_step;
                phase_nxt   = qpc_pkg::phase_after_b(phase_r);
                last_b_nxt  = now_r;
              end
            end
            qpc_pkg::OP_READ: begin
              // Load the magnitude of the pending change as the dividend
              neg_nxt   = pending_r[AW-1];
              mag_nxt   = pending_r[AW-1] ? (~pending_r + AW'(1)) : pending_r;
              rem_nxt   = '0;
              cnt_nxt   = CNT_W'(AW);
              la_nxt    = in_item.level_a;
              lb_nxt    = in_item.level_b;
              state_nxt = ST_DIV;
            end
            qpc_pkg::OP_RESTART: begin
              pos_nxt   = (init_now > range_now) ? range_now : init_now;
              phase_nxt = qpc_pkg::phase_from_pins(in_item.level_a, in_item.level_b);
            end
            default: begin
              now_nxt = now_r;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? PW'(rem_sh - {1'b0, range_now}) : rem_sh[PW-1:0];
        mag_nxt = {mag_r[AW-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        // Hold here while an earlier result still waits
        if (out_free) begin
          pos_nxt                   = pos_fold;
          pending_nxt               = '0;
          phase_nxt                 = qpc_pkg::phase_from_pins(la_r, lb_r);
          out_valid_nxt             = 1'b1;
          out_item_nxt.position_out = qpc_pkg::POS_OUT_W'(pos_fold);
          out_item_nxt.hit_cap      = cap_fold;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r     <= qpc_pkg::RANGE_RST;
      initial_r   <= qpc_pkg::INITIAL_RST;
      wrap_r      <= qpc_pkg::WRAP_RST;
      cooldown_r  <= qpc_pkg::COOLDOWN_RST;
      pos_r       <= '0;
      phase_r     <= '0;
      pending_r   <= '0;
      now_r       <= '0;
      last_a_r    <= '0;
      last_b_r    <= '0;
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      range_r     <= range_nxt;
      initial_r   <= initial_nxt;
      wrap_r      <= wrap_nxt;
      cooldown_r  <= cooldown_nxt;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      pending_r   <= pending_nxt;
      now_r       <= now_nxt;
      last_a_r    <= last_a_nxt;
      last_b_r    <= last_b_nxt;
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    la_r       <= la_nxt;
    lb_r       <= lb_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qpc_checker.sv =====
// Port-level checker for the quadrature position counter, bound to the top
// level. Uses qpc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module qpc_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           in_valid,
  input wire                           in_stall,
  input wire qpc_pkg::in_item_t        in_item,
  input wire                           out_valid,
  input wire                           out_stall,
  input wire qpc_pkg::out_item_t       out_item,
  input wire                           cfg_we,
  input wire [qpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire [qpc_pkg::REG_W-1:0]      cfg_wdata
);

  logic read_fire;
  logic other_fire;
  logic cfg_seen;

  assign read_fire  = in_valid && !in_stall && (in_item.opcode == qpc_pkg::OP_READ);
  assign other_fire = in_valid && !in_stall && (in_item.opcode != qpc_pkg::OP_READ);
  assign cfg_seen   = cfg_we && (cfg_index == cfg_index) && (cfg_wdata == cfg_wdata);

  // A stalled result holds
  `QPC_ASSERT_IMPLY(a_out_hold, clk, rst_n, out_valid && out_stall, ##1 (out_valid && $stable(out_item)))

  // Reset empties the result channel and opens the input
  `QPC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n, ##1 (!out_valid && !in_stall))

  // A read accepted without a configuration write occupies the block for the division that follows
  `QPC_ASSERT_IMPLY(a_read_busy, clk, rst_n, read_fire && !cfg_seen, ##1 in_stall)

  // Only a read produces a result
  `QPC_ASSERT_IMPLY(a_no_spurious, clk, rst_n, other_fire && !out_valid, ##1 !out_valid)

endmodule

bind quadrature_position_counter qpc_checker u_qpc_checker (.*);

`default_nettype wire
